// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files of the byte decompressor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lzbd_pkg.sv =====
// Types and constants shared by the byte decompressor modules.
package lzbd_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 6;
  // A distance is a 10-bit offset plus one, so it spans 1 to 1024.
  localparam int DIST_W = 11;

  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;

  // Parser position within a token.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MARK  = 2'd1,
    PH_TOKEN = 2'd2
  } phase_t;

  // Sequencer states: take a word, read the window, emit a copied byte.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_COPY = 2'd2
  } seq_state_t;

endpackage

// ===== hdl/lzbd_alu.sv =====
// Address unit: window read address and history hit check for a copy.
module lzbd_alu #(
  parameter int WINDOW_DEPTH = 1024,
  localparam int AW = $clog2(WINDOW_DEPTH),
  localparam int FW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic [AW-1:0]                  wr_idx,
  input  logic [lzbd_pkg::DIST_W-1:0]    distance,
  input  logic [FW-1:0]                  fill,
  output logic [AW-1:0]                  rd_addr,
  output logic                           hit
);

  localparam int CW = ((AW > lzbd_pkg::DIST_W) ? AW : lzbd_pkg::DIST_W) + 2;

  logic [CW-1:0] depth_c;
  logic [CW-1:0] dist_c;
  logic [CW-1:0] back_c;
  logic [CW-1:0] wr_c;
  logic [CW-1:0] rd_c;

  // A distance equal to the depth lands on the entry about to be overwritten.
  always_comb begin
    depth_c = CW'(WINDOW_DEPTH);
    dist_c  = CW'(distance);
    wr_c    = CW'(wr_idx);
    back_c  = (dist_c == depth_c) ? '0 : dist_c;
    rd_c    = (wr_c >= back_c) ? (wr_c - back_c) : (wr_c + depth_c - back_c);
    rd_addr = rd_c[AW-1:0];
    // The entry holds real history only once that many bytes were written.
    hit     = (CW'(fill) >= dist_c);
  end

endmodule

// ===== hdl/lzbd_window.sv =====
// History window memory: one write port and one registered read port.
module lzbd_window #(
  parameter int WINDOW_DEPTH = 1024,
  localparam int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lzbd_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lzbd_pkg::BYTE_W-1:0] rd_data
);

  logic [lzbd_pkg::BYTE_W-1:0] mem [WINDOW_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/lzbd_top_note.sv =====
// Byte emission bookkeeping: window write pointer, fill level and output position.
module lzbd_track #(
  parameter int WINDOW_DEPTH = 1024,
  localparam int AW = $clog2(WINDOW_DEPTH),
  localparam int FW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       emit,
  output logic [AW-1:0]              wr_idx,
  output logic [FW-1:0]              fill,
  output logic [lzbd_pkg::POS_W-1:0] count
);

  logic [AW-1:0]              wr_idx_r;
  logic [AW-1:0]              wr_idx_nxt;
  logic [FW-1:0]              fill_r;
  logic [FW-1:0]              fill_nxt;
  logic [lzbd_pkg::POS_W-1:0] count_r;
  logic [lzbd_pkg::POS_W-1:0] count_nxt;

  // Each emitted byte advances the pointer, the saturating fill and the position.
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    if (emit) begin
      wr_idx_nxt = (wr_idx_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_r + AW'(1);
      fill_nxt   = (fill_r == FW'(WINDOW_DEPTH)) ? fill_r : fill_r + FW'(1);
      count_nxt  = count_r + lzbd_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      fill_r   <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      count_r  <= count_nxt;
    end
  end

  assign wr_idx = wr_idx_r;
  assign fill   = fill_r;
  assign count  = count_r;

endmodule

// ===== hdl/lzss_byte_decompressor.sv =====
// LZSS byte decompressor top level: token parser, copy sequencer and output register.
//
// Compressed words enter one byte at a time on the in_ side; decompressed bytes leave on
// the out_ side with their stream position and a tlast on the final byte that each input
// word produces. A literal leaves in the cycle after it is accepted, and a marker or token
// byte that completes nothing is taken without output. A copy token holds the input from
// its third byte until its last byte is emitted; each copied byte gets its window read
// address and registered memory read in the read state, then is emitted and written back
// into the same window in the copy state, so overlapping copies see the bytes just produced.
// A stalled output holds the copy state. The window needs no clearing pass after reset:
// a fill count marks how much history exists, and a reference further back reads as zero.
`include "assert_macros.svh"

module lzss_byte_decompressor #(
  parameter int WINDOW_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] out_position
  output logic        out_tlast   // run_last
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);

  lzbd_pkg::seq_state_t state_r, state_nxt;
  lzbd_pkg::phase_t     phase_r, phase_nxt;

  logic [lzbd_pkg::BYTE_W-1:0] tok_r, tok_nxt;
  logic [lzbd_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [lzbd_pkg::LEN_W-1:0]  remain_r, remain_nxt;
  logic                        hit_r, hit_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [lzbd_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [lzbd_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        out_free;
  logic                        emit;
  logic [lzbd_pkg::BYTE_W-1:0] emit_byte;
  logic                        emit_last;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        alu_hit;
  logic [lzbd_pkg::BYTE_W-1:0] rd_data;
  logic [AW-1:0]               wr_idx;
  logic [FW-1:0]               fill;
  logic [lzbd_pkg::POS_W-1:0]  count;

  lzbd_alu #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_alu (
    .wr_idx   (wr_idx),
    .distance (dist_r),
    .fill     (fill),
    .rd_addr  (rd_addr),
    .hit      (alu_hit)
  );

  lzbd_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
    .clk     (clk),
    .wr_en   (emit),
    .wr_addr (wr_idx),
    .wr_data (emit_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lzbd_track #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .emit   (emit),
    .wr_idx (wr_idx),
    .fill   (fill),
    .count  (count)
  );

  // The output register can take a new word when empty or draining this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == lzbd_pkg::ST_IDLE) && out_free;

  // Parser and copy sequencer.
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    tok_nxt    = tok_r;
    dist_nxt   = dist_r;
    remain_nxt = remain_r;
    hit_nxt    = hit_r;
    emit       = 1'b0;
    emit_byte  = '0;
    emit_last  = 1'b0;
    rd_en      = 1'b0;
    case (state_r)
      lzbd_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (phase_r)
            lzbd_pkg::PH_MARK: begin
              // Zero length after a marker is an escaped marker byte.
              if (in_tdata[lzbd_pkg::LEN_W-1:0] == '0) begin
                emit      = 1'b1;
                emit_byte = lzbd_pkg::MARKER_BYTE;
                emit_last = 1'b1;
                phase_nxt = lzbd_pkg::PH_IDLE;
              end else begin
                tok_nxt   = in_tdata;
                phase_nxt = lzbd_pkg::PH_TOKEN;
              end
            end
            lzbd_pkg::PH_TOKEN: begin
              dist_nxt   = {1'b0, tok_r[7:6], in_tdata} + lzbd_pkg::DIST_W'(1);
              remain_nxt = tok_r[lzbd_pkg::LEN_W-1:0];
              state_nxt  = lzbd_pkg::ST_READ;
              phase_nxt  = lzbd_pkg::PH_IDLE;
            end
            default: begin
              if (in_tdata == lzbd_pkg::MARKER_BYTE) begin
                phase_nxt = lzbd_pkg::PH_MARK;
              end else begin
                emit      = 1'b1;
                emit_byte = in_tdata;
                emit_last = 1'b1;
                phase_nxt = lzbd_pkg::PH_IDLE;
              end
            end
          endcase
          // End of stream drops any half-parsed token.
          if (in_tlast) begin
            phase_nxt = lzbd_pkg::PH_IDLE;
            tok_nxt   = '0;
          end
        end
      end
      lzbd_pkg::ST_READ: begin
        rd_en     = 1'b1;
        hit_nxt   = alu_hit;
        state_nxt = lzbd_pkg::ST_COPY;
      end
      lzbd_pkg::ST_COPY: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = hit_r ? rd_data : '0;
          emit_last  = (remain_r == lzbd_pkg::LEN_W'(1));
          remain_nxt = remain_r - lzbd_pkg::LEN_W'(1);
          state_nxt  = emit_last ? lzbd_pkg::ST_IDLE : lzbd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = lzbd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register loading.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_pos_nxt   = count;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzbd_pkg::ST_IDLE;
      phase_r     <= lzbd_pkg::PH_IDLE;
      tok_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tok_r       <= tok_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    hit_r      <= hit_nxt;
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;

  // A copy in progress always has bytes left to produce.
  `ASSERT_IMPLY(a_copy_len, clk, rst_n, state_r != lzbd_pkg::ST_IDLE, remain_r != '0, "copy with no bytes left")

  // The last copied byte returns the sequencer to idle.
  `ASSERT_NEXT(a_copy_end, clk, rst_n, emit && (state_r == lzbd_pkg::ST_COPY) && emit_last, state_r == lzbd_pkg::ST_IDLE, "copy did not end")

  // Consecutive output words carry consecutive positions.
  `ASSERT_NEXT(a_pos_step, clk, rst_n, out_tvalid && out_tready, !out_tvalid || (out_pos_r == $past(out_pos_r) + 16'd1), "output position skipped")

  // The fill count never runs past the window depth.
  `ASSERT_IMPLY(a_fill_cap, clk, rst_n, emit, fill <= FW'(WINDOW_DEPTH), "fill count overflow")

endmodule
